// ===== hdl/davi_pkg.sv =====
// Shared constants for the dual accelerometer velocity integrator.
// Holds field widths, configuration register indexes and reset values.
// Depends on nothing; imported by the top level and its checker.
package davi_pkg;

  // Payload and configuration port widths.
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Default sample counter width.
  localparam int unsigned WINDOW_BITS_DEFAULT = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_BAND  = 3'd6;

  // Configuration reset values.
  localparam logic [23:0] GAIN_A_RST      = 24'd9190;
  localparam logic [23:0] GAIN_B_RST      = 24'd11296;
  localparam logic [20:0] GRAVITY_RST     = 21'd642908;
  localparam logic [20:0] THRESHOLD_RST   = 21'd19661;
  localparam logic [9:0]  WINDOW_LEN_RST  = 10'd100;
  localparam logic [15:0] STEP_SCALE_RST  = 16'd6554;
  localparam logic [15:0] STILL_BAND_RST  = 16'd1311;

endpackage

// ===== hdl/dual_accel_velocity_integrator.sv =====
// Usage
// -----
// Each input request carries one pair of raw z-axis samples (channels A and B).
// Samples are scaled to Q15.16, gravity is removed, a shared dead zone is
// applied, and the pair is summed into the current window. At the end of a
// window both sums are averaged, scaled by the time step and added to the
// previous velocities; a still test on channel A may force both to zero.
// One output request then carries both velocities and the window count.
// Input channel: in_valid_i / in_stall_o. Output channel: out_valid_o /
// out_stall_i. Configuration: cfg_we_i writes cfg_data_i to register
// cfg_index_i; the user must write only while no request is in flight, as the
// block itself does not enforce it. A sample that does not close a window is
// accepted, takes two passes through one shared scaling multiplier and then
// the accumulate step. A window-closing sample then runs, for each channel,
// the divider load, the shared one-bit-per-cycle divider, the time step product
// and the velocity add, before the result is loaded into the output register.
// A pending result sits in the output register while the next sample is taken;
// a new result waits in place until that register is free.
// Reset clears the configuration to its defaults, the sums, the velocities,
// the sample counter and the window count; no result is pending after reset.
module dual_accel_velocity_integrator
  import davi_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input samples.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [RAW_W-1:0]     accel_raw_a_i,
  input  logic signed [RAW_W-1:0]     accel_raw_b_i,
  // Velocity results.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [VEL_W-1:0]     velocity_a_o,
  output logic signed [VEL_W-1:0]     velocity_b_o,
  output logic [COUNT_W-1:0]          window_count_o,
  // Configuration writes.
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned SUM_W   = VEL_W + WINDOW_BITS;
  localparam int unsigned CNT_W   = $clog2(SUM_W);
  localparam int unsigned PROD_W  = RAW_W + 25;
  localparam int unsigned PROD2_W = SUM_W + 16;
  localparam int unsigned SAT_W   = SUM_W + 3;
  localparam int unsigned LEN_W   = 17;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'((1 << WINDOW_BITS) - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_OFS  = 9'b000000100,
    ST_ACC  = 9'b000001000,
    ST_DLD  = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_STEP = 9'b001000000,
    ST_ADD  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [VEL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-VEL_W:0] hi;
    hi = v[SAT_W-1:VEL_W-1];
    if (&hi || ~|hi) begin
      sat32 = v[VEL_W-1:0];
    end else if (v[SAT_W-1]) begin
      sat32 = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

  // Control state.
  state_e                   state_q, state_d;
  logic                     ch_q;
  logic [WINDOW_BITS-1:0]   cnt_q;
  logic [COUNT_W-1:0]       windows_q;
  logic [CNT_W-1:0]         div_cnt_q;
  logic                     out_valid_q;
  logic signed [SUM_W-1:0]  sum_a_q, sum_b_q;
  logic signed [VEL_W-1:0]  prev_a_q, prev_b_q;

  // Configuration registers.
  logic [23:0] gain_a_q, gain_b_q;
  logic [20:0] gravity_q, threshold_q;
  logic [9:0]  window_len_q;
  logic [15:0] step_scale_q, still_band_q;

  // Datapath registers.
  logic signed [RAW_W-1:0]  raw_a_q, raw_b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [VEL_W-1:0]  accel_a_q, accel_b_q;
  logic [SUM_W-1:0]         quo_q;
  logic [WINDOW_BITS-1:0]   rem_q;
  logic                     neg_q;
  logic [PROD2_W-1:0]       prod2_q;
  logic signed [VEL_W-1:0]  vnew_a_q, vnew_b_q;
  logic signed [VEL_W-1:0]  vel_a_q, vel_b_q;

  // Shared scaling multiplier: raw sample times channel gain.
  logic signed [RAW_W-1:0]  mul_raw;
  logic [23:0]              mul_gain;
  logic signed [PROD_W-1:0] prod_c;
  assign mul_raw  = ch_q ? raw_b_q : raw_a_q;
  assign mul_gain = ch_q ? gain_b_q : gain_a_q;
  assign prod_c   = PROD_W'(mul_raw) * $signed({1'b0, mul_gain});

  // Floor shift, gravity removal and saturation.
  logic signed [SAT_W-1:0]  ofs_c;
  logic signed [VEL_W-1:0]  accel_c;
  assign ofs_c   = SAT_W'($signed(prod_q[PROD_W-1:8])) - $signed(SAT_W'(gravity_q));
  assign accel_c = sat32(ofs_c);

  // Dead zone on the magnitude of both channels.
  logic [VEL_W:0]          mag_a, mag_b;
  logic                    dead;
  logic signed [VEL_W-1:0] add_a, add_b;
  assign mag_a = accel_a_q[VEL_W-1] ? -(VEL_W+1)'(accel_a_q) : (VEL_W+1)'(accel_a_q);
  assign mag_b = accel_b_q[VEL_W-1] ? -(VEL_W+1)'(accel_b_q) : (VEL_W+1)'(accel_b_q);
  assign dead  = (mag_a < (VEL_W+1)'(threshold_q)) || (mag_b < (VEL_W+1)'(threshold_q));
  assign add_a = dead ? '0 : accel_a_q;
  assign add_b = dead ? '0 : accel_b_q;

  // Window length clamp and end-of-window test.
  logic [LEN_W-1:0]       len_one, len_c;
  logic [WINDOW_BITS-1:0] len_w, cnt_next;
  logic                   win_end;
  assign len_one  = (window_len_q == '0) ? LEN_W'(1) : LEN_W'(window_len_q);
  assign len_c    = (len_one > MAX_LEN) ? MAX_LEN : len_one;
  assign len_w    = len_c[WINDOW_BITS-1:0];
  assign cnt_next = cnt_q + WINDOW_BITS'(1);
  assign win_end  = (cnt_next == '0) || (cnt_next >= len_w);

  // Divider load: magnitude and sign of the selected sum.
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  assign sum_sel = ch_q ? sum_b_q : sum_a_q;
  assign sum_mag = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;

  // Restoring divider, one quotient bit per cycle.
  logic [WINDOW_BITS:0] rem_sh, rem_diff;
  logic                 q_bit;
  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, len_w};
  assign q_bit    = (rem_sh >= {1'b0, len_w});

  // Time step product and velocity update.
  logic [PROD2_W-1:0]       prod2_c;
  logic [SUM_W:0]           step_mag;
  logic signed [SUM_W+1:0]  delta;
  logic signed [VEL_W-1:0]  prev_sel;
  logic signed [SAT_W-1:0]  vsum;
  logic signed [VEL_W-1:0]  vnew_c;
  assign prod2_c  = PROD2_W'(quo_q) * PROD2_W'(step_scale_q);
  assign step_mag = {1'b0, prod2_q[PROD2_W-1:16]} + (SUM_W+1)'(neg_q && (|prod2_q[15:0]));
  assign delta    = neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
  assign prev_sel = ch_q ? prev_b_q : prev_a_q;
  assign vsum     = SAT_W'(prev_sel) + SAT_W'(delta);
  assign vnew_c   = sat32(vsum);

  // Still band test on channel A.
  logic signed [VEL_W+1:0] band_lo, band_hi, va_ext;
  logic                    still;
  logic signed [VEL_W-1:0] va_fin, vb_fin;
  assign band_lo = (VEL_W+2)'(prev_a_q) - $signed((VEL_W+2)'(still_band_q));
  assign band_hi = (VEL_W+2)'(prev_a_q) + $signed((VEL_W+2)'(still_band_q));
  assign va_ext  = (VEL_W+2)'(vnew_a_q);
  assign still   = (va_ext > band_lo) && (va_ext < band_hi);
  assign va_fin  = still ? '0 : vnew_a_q;
  assign vb_fin  = still ? '0 : vnew_b_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OFS;
      ST_OFS:  state_d = ch_q ? ST_ACC : ST_MUL;
      ST_ACC:  state_d = win_end ? ST_DLD : ST_IDLE;
      ST_DLD:  state_d = ST_DIV;
      ST_DIV:  if (div_cnt_q == DIV_LAST) state_d = ST_STEP;
      ST_STEP: state_d = ST_ADD;
      ST_ADD:  state_d = ch_q ? ST_OUT : ST_DLD;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= 1'b0;
      cnt_q        <= '0;
      windows_q    <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      sum_a_q      <= '0;
      sum_b_q      <= '0;
      prev_a_q     <= '0;
      prev_b_q     <= '0;
      gain_a_q     <= GAIN_A_RST;
      gain_b_q     <= GAIN_B_RST;
      gravity_q    <= GRAVITY_RST;
      threshold_q  <= THRESHOLD_RST;
      window_len_q <= WINDOW_LEN_RST;
      step_scale_q <= STEP_SCALE_RST;
      still_band_q <= STILL_BAND_RST;
      vel_a_q      <= '0;
      vel_b_q      <= '0;
    end else begin
      state_q <= state_d;

      // Configuration writes; unused indexes are ignored.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_GAIN_A:     gain_a_q     <= cfg_data_i;
          REG_GAIN_B:     gain_b_q     <= cfg_data_i;
          REG_GRAVITY:    gravity_q    <= cfg_data_i[20:0];
          REG_THRESHOLD:  threshold_q  <= cfg_data_i[20:0];
          REG_WINDOW_LEN: window_len_q <= cfg_data_i[9:0];
          REG_STEP_SCALE: step_scale_q <= cfg_data_i[15:0];
          REG_STILL_BAND: still_band_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // Result register loads a new result, or drains when taken.
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_OFS: ch_q <= !ch_q;
        ST_ACC: begin
          sum_a_q <= sum_a_q + SUM_W'(add_a);
          sum_b_q <= sum_b_q + SUM_W'(add_b);
          cnt_q   <= win_end ? '0 : cnt_next;
        end
        ST_DLD: div_cnt_q <= '0;
        ST_DIV: div_cnt_q <= div_cnt_q + CNT_W'(1);
        ST_ADD: ch_q <= !ch_q;
        ST_OUT: begin
          if (out_free) begin
            prev_a_q  <= va_fin;
            prev_b_q  <= vb_fin;
            vel_a_q   <= va_fin;
            vel_b_q   <= vb_fin;
            sum_a_q   <= '0;
            sum_b_q   <= '0;
            windows_q <= windows_q + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          raw_a_q <= accel_raw_a_i;
          raw_b_q <= accel_raw_b_i;
        end
      end
      ST_MUL: prod_q <= prod_c;
      ST_OFS: begin
        if (ch_q) accel_b_q <= accel_c;
        else accel_a_q <= accel_c;
      end
      ST_DLD: begin
        quo_q <= sum_mag;
        rem_q <= '0;
        neg_q <= sum_sel[SUM_W-1];
      end
      ST_DIV: begin
        rem_q <= q_bit ? rem_diff[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
        quo_q <= {quo_q[SUM_W-2:0], q_bit};
      end
      ST_STEP: prod2_q <= prod2_c;
      ST_ADD: begin
        if (ch_q) vnew_b_q <= vnew_c;
        else vnew_a_q <= vnew_c;
      end
      default: ;
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign velocity_a_o   = vel_a_q;
  assign velocity_b_o   = vel_b_q;
  assign window_count_o = windows_q;

endmodule

// ===== hdl/davi_checker.sv =====
// Port-level checks for the dual accelerometer velocity integrator.
// Depends on davi_pkg; attached to the top level by the bind at the end.
module davi_checker
  import davi_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VEL_W-1:0] velocity_a_o,
  input logic signed [VEL_W-1:0] velocity_b_o,
  input logic [COUNT_W-1:0]      window_count_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(velocity_a_o) &&
      $stable(velocity_b_o) && $stable(window_count_o))
    else $error("stalled result changed");

  // A result raised on an idle output carries the next window count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> window_count_o == $past(window_count_o) + COUNT_W'(1))
    else $error("window count skipped or repeated");

  // An accepted request keeps the input stalled through scaling and accumulation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1
      in_stall_o ##1 in_stall_o)
    else $error("input accepted during processing");

endmodule

bind dual_accel_velocity_integrator davi_checker u_davi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .velocity_a_o   (velocity_a_o),
  .velocity_b_o   (velocity_b_o),
  .window_count_o (window_count_o)
);
